// ===== hw/rtl/smasm_pkg.sv =====
// Shared types and codes for the square matrix add/subtract/multiply unit.
package smasm_pkg;

	localparam int ELEM_W = 16;

	localparam logic [1:0] REQ_WR_A  = 2'd0;
	localparam logic [1:0] REQ_WR_B  = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_SUB  = 2'd1;
	localparam logic [1:0] OP_MUL  = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic       wr_a;
		logic       wr_b;
		logic       rd_en;
		logic       rd_first;
		logic       rd_last;
		logic       put;
		logic       put_last;
		logic [1:0] put_row;
		logic [1:0] put_col;
		logic [1:0] op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic acc_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ===== hw/rtl/smasm_ctrl.sv =====
// Controller: request decode, element and term sequencing for one run.
module smasm_ctrl #(
	parameter int MATRIX_DIM = 4,
	parameter int ADDR_W     = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            req_type,
	input  logic [1:0]            row_index,
	input  logic [1:0]            col_index,
	input  logic [1:0]            operation,
	output logic [ADDR_W-1:0]     wr_addr,
	output logic [ADDR_W-1:0]     rd_addr_a,
	output logic [ADDR_W-1:0]     rd_addr_b,
	output smasm_pkg::ctrl_cmd_t  cmd,
	input  smasm_pkg::ctrl_sts_t  sts
);
	import smasm_pkg::*;

	localparam int IDX_W = $clog2(MATRIX_DIM);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MATRIX_DIM - 1);

	state_t           state_q, state_d;
	logic [1:0]       op_q, op_d;
	logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic             accept, in_range, is_mul, k_last, elem_last;

	assign accept    = in_valid && in_ready;
	assign in_range  = ({30'd0, row_index} < 32'(MATRIX_DIM)) &&
	                   ({30'd0, col_index} < 32'(MATRIX_DIM));
	assign is_mul    = (op_q == OP_MUL);
	assign k_last    = !is_mul || (k_q == IDX_MAX);
	assign elem_last = (i_q == IDX_MAX) && (j_q == IDX_MAX);
	assign wr_addr   = ADDR_W'(32'(row_index) * MATRIX_DIM + 32'(col_index));

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		i_d       = i_q;
		j_d       = j_q;
		k_d       = k_q;
		in_ready  = 1'b0;
		rd_addr_a = ADDR_W'(32'(i_q) * MATRIX_DIM + 32'(j_q));
		rd_addr_b = ADDR_W'(32'(i_q) * MATRIX_DIM + 32'(j_q));
		cmd       = '0;
		cmd.op    = op_q;
		cmd.put_row  = 2'(i_q);
		cmd.put_col  = 2'(j_q);
		cmd.put_last = elem_last;
		if (is_mul) begin
			rd_addr_a = ADDR_W'(32'(i_q) * MATRIX_DIM + 32'(k_q));
			rd_addr_b = ADDR_W'(32'(k_q) * MATRIX_DIM + 32'(j_q));
		end
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					cmd.wr_a = (req_type == REQ_WR_A) && in_range;
					cmd.wr_b = (req_type == REQ_WR_B) && in_range;
					if (req_type == REQ_START && operation != OP_RSVD) begin
						op_d    = operation;
						i_d     = '0;
						j_d     = '0;
						k_d     = '0;
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_first = (k_q == '0);
				cmd.rd_last  = k_last;
				if (k_last) begin
					k_d     = '0;
					state_d = ST_WAIT;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_WAIT: begin
				if (sts.acc_done && sts.out_free) begin
					cmd.put = 1'b1;
					if (elem_last) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_READ;
						if (j_q == IDX_MAX) begin
							j_d = '0;
							i_d = i_q + 1'b1;
						end else begin
							j_d = j_q + 1'b1;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_ADD;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

endmodule

// ===== hw/rtl/smasm_dp.sv =====
// Datapath: element stores, multiply/add/subtract stage, accumulator and output register.
module smasm_dp #(
	parameter int MATRIX_DIM    = 4,
	parameter int FRACTION_BITS = 8,
	parameter int ADDR_W        = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  logic signed [15:0]    wr_data,
	input  logic [ADDR_W-1:0]     rd_addr_a,
	input  logic [ADDR_W-1:0]     rd_addr_b,
	input  smasm_pkg::ctrl_cmd_t  cmd,
	output smasm_pkg::ctrl_sts_t  sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            out_row,
	output logic [1:0]            out_col,
	output logic signed [15:0]    out_value,
	output logic                  out_last
);
	import smasm_pkg::*;

	localparam int DEPTH  = MATRIX_DIM * MATRIX_DIM;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int ACC_W  = PROD_W + $clog2(MATRIX_DIM) + 1;
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

	logic signed [ELEM_W-1:0] mem_a [DEPTH];
	logic signed [ELEM_W-1:0] mem_b [DEPTH];

	logic signed [ELEM_W-1:0] a_s1, b_s1;
	logic                     valid_s1, first_s1, last_s1;
	logic signed [PROD_W-1:0] term_s2;
	logic                     valid_s2, first_s2, last_s2;
	logic signed [ACC_W-1:0]  acc_q, scaled;
	logic                     acc_done_q, out_valid_q;
	logic signed [ELEM_W-1:0] sat_value;
	logic [1:0]               row_q, col_q;
	logic signed [ELEM_W-1:0] value_q;
	logic                     last_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			mem_a[wr_addr] <= wr_data;
		end
		if (cmd.wr_b) begin
			mem_b[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			a_s1 <= mem_a[rd_addr_a];
			b_s1 <= mem_b[rd_addr_b];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_MUL:  term_s2 <= a_s1 * b_s1;
			OP_SUB:  term_s2 <= PROD_W'(a_s1) - PROD_W'(b_s1);
			default: term_s2 <= PROD_W'(a_s1) + PROD_W'(b_s1);
		endcase
		if (valid_s2) begin
			acc_q <= first_s2 ? ACC_W'(term_s2) : acc_q + ACC_W'(term_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			first_s1   <= 1'b0;
			last_s1    <= 1'b0;
			valid_s2   <= 1'b0;
			first_s2   <= 1'b0;
			last_s2    <= 1'b0;
			acc_done_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			first_s1 <= cmd.rd_first;
			last_s1  <= cmd.rd_last;
			valid_s2 <= valid_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			if (cmd.put) begin
				acc_done_q <= 1'b0;
			end else if (valid_s2 && last_s2) begin
				acc_done_q <= 1'b1;
			end
		end
	end

	always_comb begin
		scaled = (cmd.op == OP_MUL) ? (acc_q >>> FRACTION_BITS) : acc_q;
		if (scaled > SAT_MAX) begin
			sat_value = 16'sh7FFF;
		end else if (scaled < SAT_MIN) begin
			sat_value = -16'sh8000;
		end else begin
			sat_value = ELEM_W'(scaled);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			row_q   <= cmd.put_row;
			col_q   <= cmd.put_col;
			value_q <= sat_value;
			last_q  <= cmd.put_last;
		end
	end

	assign sts.acc_done = acc_done_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_row      = row_q;
	assign out_col      = col_q;
	assign out_value    = value_q;
	assign out_last     = last_q;

endmodule

// ===== hw/rtl/square_matrix_add_sub_multiply_unit.sv =====
// Top level of the square matrix add/subtract/multiply unit.
// Load beats are accepted back to back while idle.
// A start beat with a non-reserved operation yields MATRIX_DIM*MATRIX_DIM result beats;
// elements are computed one at a time: multiply reads one store read pair per term for
// MATRIX_DIM terms, add/subtract reads one pair, and an output stall holds the next element.
// Reset clears control and the output valid flag; stores and output data are undefined.
module square_matrix_add_sub_multiply_unit #(
	parameter int MATRIX_DIM    = 4,
	parameter int FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // row_index, col_index, element_value, operation
	input  logic [1:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // out_row, out_col, out_value
	output logic        m_tlast   // last_element
);
	import smasm_pkg::*;

	localparam int ADDR_W = $clog2(MATRIX_DIM * MATRIX_DIM);

	ctrl_cmd_t          cmd;
	ctrl_sts_t          sts;
	logic [ADDR_W-1:0]  wr_addr, rd_addr_a, rd_addr_b;
	logic [1:0]         out_row, out_col;
	logic signed [15:0] out_value;

	smasm_ctrl #(
		.MATRIX_DIM (MATRIX_DIM),
		.ADDR_W     (ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.req_type  (s_tuser),
		.row_index (s_tdata[1:0]),
		.col_index (s_tdata[3:2]),
		.operation (s_tdata[21:20]),
		.wr_addr   (wr_addr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.cmd       (cmd),
		.sts       (sts)
	);

	smasm_dp #(
		.MATRIX_DIM    (MATRIX_DIM),
		.FRACTION_BITS (FRACTION_BITS),
		.ADDR_W        (ADDR_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_addr   (wr_addr),
		.wr_data   (s_tdata[19:4]),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'd0, out_value, out_col, out_row};

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the square matrix add/subtract/multiply unit.
`timescale 1ns / 100ps

module testbench;
	import smasm_pkg::*;

	localparam int DIM        = 4;
	localparam int FRAC       = 8;
	localparam int CELLS      = DIM * DIM;
	localparam int RAND_ITEMS = 190;
	localparam int CYCLE_CAP  = 200000;
	localparam int HOLD_LEN   = 300;
	localparam int SETTLE     = 2 * (DIM + 4);

	localparam logic [1:0] REQ_IGNORED  = 2'd3;

	typedef struct packed {
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [15:0] value;
		logic               last;
	} result_beat_t;

	class matrix_scoreboard;
		logic signed [15:0] a_cells [CELLS];
		logic signed [15:0] b_cells [CELLS];
		result_beat_t       expected_beats [$];
		int                 error_count   = 0;
		int                 checked_count = 0;
		int                 load_count    = 0;
		int                 ignored_count = 0;
		int                 start_count [3] = '{0, 0, 0};

		function logic signed [15:0] element_result(logic [1:0] op, int r, int c);
			longint acc, av, bv;
			acc = 0;
			if (op == OP_MUL) begin
				for (int k = 0; k < DIM; k++) begin
					av = a_cells[r * DIM + k];
					bv = b_cells[k * DIM + c];
					acc += av * bv;
				end
				acc = acc >>> FRAC;
			end else begin
				av = a_cells[r * DIM + c];
				bv = b_cells[r * DIM + c];
				acc = (op == OP_ADD) ? av + bv : av - bv;
			end
			if (acc > 32767)
				acc = 32767;
			else if (acc < -32768)
				acc = -32768;
			return acc[15:0];
		endfunction

		function void note_beat(logic [1:0] req, logic [23:0] data);
			logic [1:0]         row, col, op;
			logic signed [15:0] value;
			result_beat_t       beat;
			int                 idx;
			row   = data[1:0];
			col   = data[3:2];
			value = data[19:4];
			op    = data[21:20];
			idx   = row * DIM + col;
			case (req)
				REQ_WR_A: begin
					a_cells[idx] = value;
					load_count++;
				end
				REQ_WR_B: begin
					b_cells[idx] = value;
					load_count++;
				end
				REQ_START: begin
					if (op == OP_RSVD) begin
						ignored_count++;
					end else begin
						start_count[op]++;
						for (int r = 0; r < DIM; r++) begin
							for (int c = 0; c < DIM; c++) begin
								beat.row   = 2'(r);
								beat.col   = 2'(c);
								beat.value = element_result(op, r, c);
								beat.last  = (r * DIM + c == CELLS - 1);
								expected_beats.push_back(beat);
							end
						end
					end
				end
				default: ignored_count++;
			endcase
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		task report(string msg);
			error_count++;
			$display("mismatch at result %0d: %s", checked_count, msg);
		endtask

		task check_beat(logic [23:0] data, logic last);
			result_beat_t want;
			if (expected_beats.size() == 0) begin
				report($sformatf("unexpected beat data=%h last=%b", data, last));
				return;
			end
			want = expected_beats.pop_front();
			if (data[1:0] !== want.row)
				report($sformatf("row %0d, want %0d", data[1:0], want.row));
			if (data[3:2] !== want.col)
				report($sformatf("col %0d, want %0d", data[3:2], want.col));
			if (data[19:4] !== want.value)
				report($sformatf("value %h, want %h", data[19:4], want.value));
			if (last !== want.last)
				report($sformatf("last %b, want %b", last, want.last));
			checked_count++;
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // row_index, col_index, element_value, operation
	logic [1:0]  s_tuser  = '0;   // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // out_row, out_col, out_value
	logic        m_tlast;         // last_element

	matrix_scoreboard sb = new;

	int burst_left         = 0;
	int cycle_count        = 0;
	int rx_cycle           = 0;
	int results_seen       = 0;
	int hold_left          = 0;
	bit hold_done          = 1'b0;
	int held_input_cycles  = 0;

	square_matrix_add_sub_multiply_unit #(
		.MATRIX_DIM   (DIM),
		.FRACTION_BITS(FRAC)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [23:0] pack_beat(logic [1:0] row, logic [1:0] col,
			logic [15:0] value, logic [1:0] op);
		return {2'b00, op, value, col, row};
	endfunction

	function automatic logic [15:0] corner_value(int i);
		case (i)
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0001;
			3: return 16'h0000;
			4: return 16'hFFFF;
			5: return 16'h0100;
			6: return 16'hFF00;
			default: return 16'h5A5A;
		endcase
	endfunction

	function automatic logic [15:0] random_value();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return corner_value($urandom_range(0, 7));
			default: return 16'($urandom_range(0, 2047) - 1024);
		endcase
	endfunction

	task automatic send_beat(input logic [1:0] req, input logic [23:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_beat(req, data);
		burst_left--;
	endtask

	task automatic send_load();
		send_beat($urandom_range(0, 1) ? REQ_WR_B : REQ_WR_A,
			pack_beat(2'($urandom), 2'($urandom), random_value(), 2'($urandom)));
	endtask

	task automatic send_start(input logic [1:0] op);
		send_beat(REQ_START, pack_beat(2'($urandom), 2'($urandom), 16'($urandom), op));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout with %0d results outstanding", sb.pending());
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		rx_cycle++;
		if (m_tvalid && m_tready) begin
			sb.check_beat(m_tdata, m_tlast);
			results_seen++;
		end
		if (hold_left > 0 && s_tvalid && !s_tready)
			held_input_cycles++;
		if (!hold_done && results_seen >= 100) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case ((rx_cycle / 64) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rx_cycle % 4 == 0);
				default: m_tready <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	initial begin
		int counted;
		int n;
		bit paused;
		counted = 0;
		paused  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill both stores with corner values; second half of B is shifted
		for (int i = 0; i < CELLS; i++)
			send_beat(REQ_WR_A, pack_beat(2'(i / DIM), 2'(i % DIM), corner_value(i % 8),
				2'(i)));
		for (int i = 0; i < CELLS; i++)
			send_beat(REQ_WR_B, pack_beat(2'(i / DIM), 2'(i % DIM),
				corner_value((i + i / 8) % 8), 2'(i + 1)));
		send_start(OP_ADD);
		send_start(OP_SUB);
		send_start(OP_MUL);
		send_beat(REQ_IGNORED, pack_beat(2'd3, 2'd3, 16'hFFFF, OP_MUL));
		send_start(OP_RSVD);
		drain_results();

		while (counted < RAND_ITEMS) begin
			if (!paused && counted >= 120) begin
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) < 8) begin
				n = $urandom_range(0, 6);
				repeat (n) send_load();
				send_start(2'($urandom_range(0, 2)));
				counted += n + 1;
			end else begin
				case ($urandom_range(0, 2))
					0: send_beat(REQ_IGNORED, 24'($urandom));
					1: send_start(OP_RSVD);
					default: begin
						send_load();
						counted++;
					end
				endcase
			end
		end
		drain_results();

		$display("covered %0d loads, %0d add / %0d sub / %0d mul runs, %0d ignored beats",
			sb.load_count, sb.start_count[0], sb.start_count[1], sb.start_count[2],
			sb.ignored_count);
		$display("checked %0d result beats; input held off %0d cycles under output stall",
			sb.checked_count, held_input_cycles);
		if (sb.error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/smasm_pkg.sv
hw/rtl/smasm_ctrl.sv
hw/rtl/smasm_dp.sv
hw/rtl/square_matrix_add_sub_multiply_unit.sv
tb/sv/testbench.sv
